@@ design/blsm_pkg.sv @@
// Shared types, codes and sizing constants for the byte-lane load/store memory.
package blsm_pkg;

  // Memory holds 2**MEM_BYTES_LOG2 bytes; byte addresses wrap at that size.
  localparam int MEM_BYTES_LOG2 = 16;
  localparam longint unsigned MEM_DEPTH = 64'd1 << MEM_BYTES_LOG2;
  // Wide enough for a 16-bit address plus a byte offset without losing the carry.
  localparam int SUM_W = (MEM_BYTES_LOG2 > 17) ? MEM_BYTES_LOG2 : 17;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef enum logic [1:0] {
    SZ_BYTE    = 2'd0,
    SZ_HALF    = 2'd1,
    SZ_WORD    = 2'd2,
    SZ_UNKNOWN = 2'd3
  } size_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear;     // write zero at the clear counter and advance it
    logic accept;    // latch the incoming transaction
    logic wr;        // write the current byte lane
    logic rd;        // read the current byte lane
    logic advance;   // step to the next byte lane
    logic load_out;  // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic in_is_store;
    logic in_size_unknown;
    logic last_byte;
    logic out_free;
  } status_t;

  // Index of the last byte lane touched by an access of the given size.
  function automatic logic [1:0] last_lane(input size_t sz);
    logic [1:0] lane;
    unique case (sz)
      SZ_BYTE: lane = 2'd0;
      SZ_HALF: lane = 2'd1;
      SZ_WORD: lane = 2'd3;
      default: lane = 2'd0;
    endcase
    return lane;
  endfunction

endpackage

@@ design/blsm_ctrl.sv @@
// Controller state machine: clearing pass, byte-serial store and load sequencing.
module blsm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  blsm_pkg::status_t st,
  output blsm_pkg::cmd_t    cmd
);
  import blsm_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_STORE = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (st.in_size_unknown) begin
            // unknown-size store does nothing; unknown-size load returns zero
            state_nxt = st.in_is_store ? ST_IDLE : ST_RESP;
          end else if (st.in_is_store) begin
            state_nxt = ST_STORE;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_STORE: begin
        cmd.wr      = 1'b1;
        cmd.advance = 1'b1;
        if (st.last_byte) state_nxt = ST_IDLE;
      end
      ST_LOAD: begin
        cmd.rd      = 1'b1;
        cmd.advance = 1'b1;
        if (st.last_byte) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last read byte lands in the assembly register this cycle
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

@@ design/blsm_datapath.sv @@
// Datapath: byte memory, transaction latch, lane counter, load assembly and result register.
module blsm_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_op,
  input  logic [1:0]        in_access_size,
  input  logic              in_zero_extend,
  input  logic [15:0]       in_address,
  input  logic [31:0]       in_store_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_load_data,
  input  blsm_pkg::cmd_t    cmd,
  output blsm_pkg::status_t st
);
  import blsm_pkg::*;

  localparam int AW = MEM_BYTES_LOG2;

  logic [7:0]       mem_q [MEM_DEPTH];

  logic [AW-1:0]    clr_cnt_r;
  size_t            size_r;
  logic             zext_r;
  logic [15:0]      addr_r;
  logic [31:0]      sdata_r;
  logic [1:0]       lane_r;
  logic [31:0]      value_r;
  logic             rd_valid_r;
  logic [1:0]       rd_lane_r;
  logic [7:0]       rdata_r;
  logic             out_valid_r;
  logic [31:0]      out_data_r;

  logic [AW-1:0]    byte_addr;
  logic [AW-1:0]    mem_ptr;
  logic             mem_we;
  logic [7:0]       mem_wdata;
  logic [31:0]      ext_value;

  // Wrap the byte address at the memory size.
  assign byte_addr = AW'(SUM_W'(addr_r) + SUM_W'(lane_r));
  assign mem_ptr   = cmd.clear ? clr_cnt_r : byte_addr;
  assign mem_we    = cmd.clear | cmd.wr;
  assign mem_wdata = cmd.clear ? 8'h00 : sdata_r[{lane_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_ptr] <= mem_wdata;
    end else begin
      rdata_r <= mem_q[mem_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      lane_r      <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.accept) begin
        lane_r <= '0;
      end else if (cmd.advance) begin
        lane_r <= lane_r + 1'b1;
      end
      rd_valid_r <= cmd.rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size_r  <= size_t'(in_access_size);
      zext_r  <= in_zero_extend;
      addr_r  <= in_address;
      sdata_r <= in_store_data;
      value_r <= '0;
    end else if (rd_valid_r) begin
      value_r[{rd_lane_r, 3'b000} +: 8] <= rdata_r;
    end
    rd_lane_r <= lane_r;
    if (cmd.load_out) out_data_r <= ext_value;
  end

  always_comb begin
    unique case (size_r)
      SZ_BYTE: ext_value = zext_r ? {24'h000000, value_r[7:0]}
                                  : {{24{value_r[7]}}, value_r[7:0]};
      SZ_HALF: ext_value = zext_r ? {16'h0000, value_r[15:0]}
                                  : {{16{value_r[15]}}, value_r[15:0]};
      SZ_WORD: ext_value = value_r;
      default: ext_value = '0;
    endcase
  end

  assign st.clear_done      = (clr_cnt_r == {AW{1'b1}});
  assign st.in_is_store     = (in_op == OP_STORE);
  assign st.in_size_unknown = (size_t'(in_access_size) == SZ_UNKNOWN);
  assign st.last_byte       = (lane_r == last_lane(size_r));
  assign st.out_free        = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_load_data = out_data_r;

endmodule

@@ design/byte_lane_load_store_memory.sv @@
// Top level of the byte-lane load/store memory: controller and datapath.
//
// Input channel (in_valid / in_stall) carries one load or store per transaction:
// op, access_size, zero_extend, byte address and store data. Output channel
// (out_valid / out_stall) returns one 32-bit load_data per load, none per store.
// Accesses run one byte lane per cycle through a single-port byte memory, so
// the memory port sets the rate. A store is accepted, then writes its n bytes
// (n = 1, 2 or 4) before the next acceptance. A load is accepted, reads its n
// bytes, waits for the last registered read, then loads the result register,
// which drives load_data. An unknown-size store is only accepted; an
// unknown-size load is accepted and then loads a zero result.
// After reset the memory is cleared one byte per cycle, all 2**MEM_BYTES_LOG2
// bytes (65536 by default); in_stall stays high until the pass ends.
// A stalled result holds in the output register; the next transaction is
// still accepted, and a following load waits only at its result load.
module byte_lane_load_store_memory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_access_size,
  input  logic        in_zero_extend,
  input  logic [15:0] in_address,
  input  logic [31:0] in_store_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_load_data
);
  import blsm_pkg::*;

  cmd_t    cmd;
  status_t st;

  blsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  blsm_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_access_size (in_access_size),
    .in_zero_extend (in_zero_extend),
    .in_address     (in_address),
    .in_store_data  (in_store_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_load_data  (out_load_data),
    .cmd            (cmd),
    .st             (st)
  );

endmodule
